FILE: hdl/deferred_reuse_slot_allocator_defines.svh
// Assertion macros used by the checker file.
`ifndef DEFERRED_REUSE_SLOT_ALLOCATOR_DEFINES_SVH
`define DEFERRED_REUSE_SLOT_ALLOCATOR_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define DRSA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define DRSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/drsa_pkg.sv
package drsa_pkg;

    localparam int SLOTS_IN_CHUNK_DEF = 64;
    localparam int CHUNK_LIMIT_DEF    = 16;
    localparam int CLASS_BIT_DEF      = 10;

    localparam int SIZE_W   = 17;
    localparam int FRAME_W  = 64;
    localparam int SLOT_W   = 11;
    localparam int CHUNK_W  = 4;
    localparam int OFFSET_W = 22;
    localparam int DELAY_W  = 8;

    typedef enum logic [1:0] {
        CMD_ALLOCATE = 2'd0,
        CMD_RELEASE  = 2'd1,
        CMD_LOCATE   = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_POOL_ENABLE = 3'd0,
        CFG_SMALL_SIZE  = 3'd1,
        CFG_LARGE_SIZE  = 3'd2,
        CFG_MAX_REQUEST = 3'd3,
        CFG_REUSE_DELAY = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_COPY_LAST,
        ST_POP_RD,
        ST_POP_DONE,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/deferred_reuse_slot_allocator.sv
// Sequence, input transfer to result: release and clear go straight to the done state,
// locate passes through the locate state first, and allocate reads and evaluates each retired
// entry, copies the last entry into each freed place, and pops the free stack if it is not empty.
// Throughput: one item at a time; the next transfer can be taken in the cycle after the result
// leaves. The retired-list scan over registered-read memories sets the rate.
// Reset (rst_n low, asynchronous): counters cleared, registers to defaults, no memory pass.
module deferred_reuse_slot_allocator #(
    parameter int SLOTS_IN_CHUNK = drsa_pkg::SLOTS_IN_CHUNK_DEF,
    parameter int CHUNK_LIMIT    = drsa_pkg::CHUNK_LIMIT_DEF,
    parameter int CLASS_BIT      = drsa_pkg::CLASS_BIT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [2:0]                     cfg_index,
    input  logic [drsa_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     command,
    input  logic [drsa_pkg::SIZE_W-1:0]    request_size,
    input  logic [drsa_pkg::FRAME_W-1:0]   frame_number,
    input  logic [CLASS_BIT:0]             slot_id,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           ok,
    output logic [CLASS_BIT:0]             granted_slot,
    output logic                           chunk_grew,
    output logic [drsa_pkg::CHUNK_W-1:0]   chunk_index,
    output logic [drsa_pkg::OFFSET_W-1:0]  byte_offset
);

    localparam int LOCAL_SPAN = 1 << CLASS_BIT;
    localparam int CNT_W      = CLASS_BIT + 1;
    localparam int CH_W       = $clog2(CHUNK_LIMIT + 1);
    localparam int SIC_W      = (SLOTS_IN_CHUNK > 1) ? $clog2(SLOTS_IN_CHUNK) : 1;
    localparam int SPROD_W    = CNT_W + CH_W + SIC_W + 1;
    localparam int FRAME_W    = drsa_pkg::FRAME_W;
    localparam int SIZE_W     = drsa_pkg::SIZE_W;
    localparam logic [CLASS_BIT:0] NO_SLOT = {(CLASS_BIT + 1){1'b1}};

    // Memories: index is {class, local entry}.
    logic [CLASS_BIT-1:0] ret_slot_mem  [2*LOCAL_SPAN];
    logic [FRAME_W-1:0]   ret_frame_mem [2*LOCAL_SPAN];
    logic [CLASS_BIT-1:0] free_mem      [2*LOCAL_SPAN];

    // Configuration registers.
    logic              pool_enable_reg;
    logic [SIZE_W-1:0] small_size_reg, large_size_reg, max_req_reg;
    logic [7:0]        delay_reg;

    // Per-class counters.
    logic [CNT_W-1:0] ret_cnt_reg   [2];
    logic [CNT_W-1:0] free_cnt_reg  [2];
    logic [CNT_W-1:0] fresh_reg     [2];
    logic [CH_W-1:0]  chunks_reg    [2];
    logic [CNT_W-1:0] ret_cnt_next  [2];
    logic [CNT_W-1:0] free_cnt_next [2];
    logic [CNT_W-1:0] fresh_next    [2];
    logic [CH_W-1:0]  chunks_next   [2];

    drsa_pkg::state_t state_reg, state_next;

    // Captured item and scan state.
    logic [FRAME_W-1:0]   frame_reg;
    logic [CLASS_BIT:0]   sid_reg;
    logic                 cls_reg, cls_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;

    // Memory read data (registered).
    logic [CLASS_BIT-1:0] rd_slot_reg;
    logic [FRAME_W-1:0]   rd_frame_reg;
    logic [CLASS_BIT-1:0] rd_free_reg;

    // Memory ports, driven by the sequencer.
    logic                 ret_rd_en, ret_wr_en, free_rd_en, free_wr_en;
    logic [CLASS_BIT:0]   ret_rd_addr, ret_wr_addr, free_rd_addr, free_wr_addr;
    logic [CLASS_BIT-1:0] ret_wr_slot, free_wr_data;
    logic [FRAME_W-1:0]   ret_wr_frame;

    // Result register.
    logic                        out_valid_reg, out_valid_next;
    logic                        ok_reg, ok_next;
    logic [CLASS_BIT:0]          granted_reg, granted_next;
    logic                        grew_reg, grew_next;
    logic [drsa_pkg::CHUNK_W-1:0]  chunk_reg, chunk_next;
    logic [drsa_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic                        pool_clear;

    // Single 65-bit adder/compare for the reuse test: rel + delay <= now.
    logic [FRAME_W:0] due_sum;
    logic             reusable;
    assign due_sum  = {1'b0, rd_frame_reg} + {{(FRAME_W - 7){1'b0}}, delay_reg};
    assign reusable = due_sum <= {1'b0, frame_reg};

    // Locate arithmetic (one narrow multiply).
    logic [CLASS_BIT-1:0] loc_local;
    logic [CLASS_BIT-1:0] loc_chunk;
    logic [CLASS_BIT-1:0] loc_within;
    logic [SIZE_W-1:0]    loc_ssz;
    logic [SIZE_W+CLASS_BIT-1:0] loc_prod;
    assign loc_local  = sid_reg[CLASS_BIT-1:0];
    assign loc_chunk  = CLASS_BIT'(loc_local / SLOTS_IN_CHUNK);
    assign loc_within = CLASS_BIT'(loc_local % SLOTS_IN_CHUNK);
    assign loc_ssz    = sid_reg[CLASS_BIT] ? large_size_reg : small_size_reg;
    assign loc_prod   = {{SIZE_W{1'b0}}, loc_within} * {{CLASS_BIT{1'b0}}, loc_ssz};

    // Fresh-slot bound: chunks in use times slots per chunk.
    logic [SPROD_W-1:0] fresh_bound;
    assign fresh_bound = SPROD_W'(chunks_reg[cls_reg]) * SPROD_W'(SLOTS_IN_CHUNK);

    assign in_stall     = (state_reg != drsa_pkg::ST_IDLE) || out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign granted_slot = granted_reg;
    assign chunk_grew   = grew_reg;
    assign chunk_index  = chunk_reg;
    assign byte_offset  = offset_reg;

    logic in_xfer, out_xfer;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    function automatic logic [CLASS_BIT-1:0] last_free(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] m;
        m = cnt - CNT_W'(1);
        return m[CLASS_BIT-1:0];
    endfunction

    // Memories.
    always_ff @(posedge clk)
    begin
        if (ret_wr_en)
        begin
            ret_slot_mem[ret_wr_addr]  <= ret_wr_slot;
            ret_frame_mem[ret_wr_addr] <= ret_wr_frame;
        end
        if (ret_rd_en)
        begin
            rd_slot_reg  <= ret_slot_mem[ret_rd_addr];
            rd_frame_reg <= ret_frame_mem[ret_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_wr_en)
        begin
            free_mem[free_wr_addr] <= free_wr_data;
        end
        if (free_rd_en)
        begin
            rd_free_reg <= free_mem[free_rd_addr];
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            frame_reg <= frame_number;
            sid_reg   <= slot_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= drsa_pkg::ST_IDLE;
            cls_reg         <= 1'b0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
            ok_reg          <= 1'b0;
            granted_reg     <= NO_SLOT;
            grew_reg        <= 1'b0;
            chunk_reg       <= '0;
            offset_reg      <= '0;
            pool_enable_reg <= 1'b0;
            small_size_reg  <= SIZE_W'(256);
            large_size_reg  <= SIZE_W'(4096);
            max_req_reg     <= SIZE_W'(4096);
            delay_reg       <= 8'd4;
            for (int c = 0; c < 2; c++)
            begin
                ret_cnt_reg[c]  <= '0;
                free_cnt_reg[c] <= '0;
                fresh_reg[c]    <= '0;
                chunks_reg[c]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cls_reg       <= cls_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            granted_reg   <= granted_next;
            grew_reg      <= grew_next;
            chunk_reg     <= chunk_next;
            offset_reg    <= offset_next;
            for (int c = 0; c < 2; c++)
            begin
                ret_cnt_reg[c]  <= ret_cnt_next[c];
                free_cnt_reg[c] <= free_cnt_next[c];
                fresh_reg[c]    <= fresh_next[c];
                chunks_reg[c]   <= chunks_next[c];
            end
            if (pool_clear)
            begin
                pool_enable_reg <= 1'b0;
            end
            else if (cfg_write)
            begin
                case (drsa_pkg::cfg_idx_t'(cfg_index))
                    drsa_pkg::CFG_POOL_ENABLE: pool_enable_reg <= cfg_data[0];
                    drsa_pkg::CFG_SMALL_SIZE:  small_size_reg  <= cfg_data;
                    drsa_pkg::CFG_LARGE_SIZE:  large_size_reg  <= cfg_data;
                    drsa_pkg::CFG_MAX_REQUEST: max_req_reg     <= cfg_data;
                    drsa_pkg::CFG_REUSE_DELAY: delay_reg       <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Sequencer: walk the retired list one entry per read/evaluate pair.
    always_comb
    begin
        logic [CNT_W-1:0] last;
        logic [CNT_W-1:0] fc;
        logic [CNT_W-1:0] fresh;
        state_next     = state_reg;
        cls_next       = cls_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        granted_next   = granted_reg;
        grew_next      = grew_reg;
        chunk_next     = chunk_reg;
        offset_next    = offset_reg;
        pool_clear     = 1'b0;
        ret_cnt_next   = ret_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        fresh_next     = fresh_reg;
        chunks_next    = chunks_reg;
        ret_rd_en      = 1'b0;
        ret_wr_en      = 1'b0;
        free_rd_en     = 1'b0;
        free_wr_en     = 1'b0;
        ret_rd_addr    = {cls_reg, idx_reg[CLASS_BIT-1:0]};
        ret_wr_addr    = {cls_reg, idx_reg[CLASS_BIT-1:0]};
        ret_wr_slot    = rd_slot_reg;
        ret_wr_frame   = rd_frame_reg;
        free_rd_addr   = '0;
        free_wr_addr   = '0;
        free_wr_data   = rd_slot_reg;
        last           = ret_cnt_reg[cls_reg] - CNT_W'(1);
        fc             = free_cnt_reg[cls_reg];
        fresh          = fresh_reg[cls_reg];

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            drsa_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = drsa_pkg::ST_DONE;
                    ok_next      = 1'b0;
                    granted_next = NO_SLOT;
                    grew_next    = 1'b0;
                    chunk_next   = '0;
                    offset_next  = '0;
                    idx_next     = '0;
                    if (drsa_pkg::cmd_t'(command) == drsa_pkg::CMD_ALLOCATE)
                    begin
                        cls_next = request_size > small_size_reg;
                        if (pool_enable_reg && request_size <= max_req_reg)
                        begin
                            state_next = drsa_pkg::ST_SCAN_RD;
                        end
                    end
                    else if (drsa_pkg::cmd_t'(command) == drsa_pkg::CMD_RELEASE)
                    begin
                        cls_next = slot_id[CLASS_BIT];
                        if (slot_id != NO_SLOT
                            && ret_cnt_reg[slot_id[CLASS_BIT]] < CNT_W'(LOCAL_SPAN))
                        begin
                            ret_wr_en    = 1'b1;
                            ret_wr_addr  = {slot_id[CLASS_BIT],
                                ret_cnt_reg[slot_id[CLASS_BIT]][CLASS_BIT-1:0]};
                            ret_wr_slot  = slot_id[CLASS_BIT-1:0];
                            ret_wr_frame = frame_number;
                            ret_cnt_next[slot_id[CLASS_BIT]] =
                                ret_cnt_reg[slot_id[CLASS_BIT]] + CNT_W'(1);
                            ok_next = 1'b1;
                        end
                    end
                    else if (drsa_pkg::cmd_t'(command) == drsa_pkg::CMD_CLEAR)
                    begin
                        for (int c = 0; c < 2; c++)
                        begin
                            ret_cnt_next[c]  = '0;
                            free_cnt_next[c] = '0;
                            fresh_next[c]    = '0;
                            chunks_next[c]   = '0;
                        end
                        pool_clear = 1'b1;
                        ok_next    = 1'b1;
                    end
                    else
                    begin
                        // Locate: finish in the next state with the captured id.
                        state_next = drsa_pkg::ST_POP_DONE;
                    end
                end
            end

            drsa_pkg::ST_SCAN_RD:
            begin
                if (idx_reg < ret_cnt_reg[cls_reg])
                begin
                    ret_rd_en  = 1'b1;
                    state_next = drsa_pkg::ST_SCAN_EVAL;
                end
                else if (fc != '0)
                begin
                    free_rd_en    = 1'b1;
                    free_rd_addr  = {cls_reg, last_free(fc)};
                    free_cnt_next[cls_reg] = fc - CNT_W'(1);
                    state_next    = drsa_pkg::ST_POP_RD;
                end
                else
                begin
                    state_next = drsa_pkg::ST_DONE;
                    if ({{(SPROD_W - CNT_W){1'b0}}, fresh} >= fresh_bound)
                    begin
                        if (chunks_reg[cls_reg] < CH_W'(CHUNK_LIMIT)
                            && fresh < CNT_W'(LOCAL_SPAN))
                        begin
                            chunks_next[cls_reg] = chunks_reg[cls_reg] + CH_W'(1);
                            grew_next    = 1'b1;
                            ok_next      = 1'b1;
                            granted_next = {cls_reg, fresh[CLASS_BIT-1:0]};
                            fresh_next[cls_reg] = fresh + CNT_W'(1);
                        end
                    end
                    else if (fresh < CNT_W'(LOCAL_SPAN))
                    begin
                        ok_next      = 1'b1;
                        granted_next = {cls_reg, fresh[CLASS_BIT-1:0]};
                        fresh_next[cls_reg] = fresh + CNT_W'(1);
                    end
                end
            end

            drsa_pkg::ST_SCAN_EVAL:
            begin
                if (reusable && fc < CNT_W'(LOCAL_SPAN))
                begin
                    free_wr_en   = 1'b1;
                    free_wr_addr = {cls_reg, fc[CLASS_BIT-1:0]};
                    free_wr_data = rd_slot_reg;
                    free_cnt_next[cls_reg] = fc + CNT_W'(1);
                    ret_cnt_next[cls_reg]  = last;
                    // Fetch the last entry to fill the hole.
                    ret_rd_en   = 1'b1;
                    ret_rd_addr = {cls_reg, last[CLASS_BIT-1:0]};
                    state_next  = drsa_pkg::ST_COPY_LAST;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = drsa_pkg::ST_SCAN_RD;
                end
            end

            drsa_pkg::ST_COPY_LAST:
            begin
                // Write the last entry into the vacated place; examine it next.
                ret_wr_en    = 1'b1;
                ret_wr_slot  = rd_slot_reg;
                ret_wr_frame = rd_frame_reg;
                state_next   = drsa_pkg::ST_SCAN_RD;
            end

            drsa_pkg::ST_POP_RD:
            begin
                state_next   = drsa_pkg::ST_DONE;
                ok_next      = 1'b1;
                granted_next = {cls_reg, rd_free_reg};
            end

            drsa_pkg::ST_POP_DONE:
            begin
                // Locate result.
                state_next = drsa_pkg::ST_DONE;
                if (sid_reg != NO_SLOT)
                begin
                    chunk_next  = loc_chunk[drsa_pkg::CHUNK_W-1:0];
                    offset_next = loc_prod[drsa_pkg::OFFSET_W-1:0];
                    ok_next     = {{(CLASS_BIT + 1 - CH_W){1'b0}}, chunks_reg[sid_reg[CLASS_BIT]]}
                                  > {1'b0, loc_chunk};
                end
            end

            drsa_pkg::ST_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = drsa_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = drsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/drsa_checker.sv
`include "deferred_reuse_slot_allocator_defines.svh"

module drsa_checker #(
    parameter int CLASS_BIT = drsa_pkg::CLASS_BIT_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          ok,
    input logic [CLASS_BIT:0]            granted_slot,
    input logic                          chunk_grew,
    input logic [drsa_pkg::CHUNK_W-1:0]  chunk_index,
    input logic [drsa_pkg::OFFSET_W-1:0] byte_offset
);

    // A held result keeps its payload.
    `DRSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(granted_slot) && $stable(ok), "result changed while stalled")
    // Input is never taken while a result waits.
    `DRSA_ASSERT_IMP(a_busy_stall, out_valid, in_stall, "input open while result pending")
    // A grown chunk implies a granted slot.
    `DRSA_ASSERT_IMP(a_grew_ok, out_valid && chunk_grew, ok && granted_slot != {(CLASS_BIT + 1){1'b1}}, "chunk grew on failure")
    // Allocate results never carry a location.
    `DRSA_ASSERT_IMP(a_grant_noloc, out_valid && granted_slot != {(CLASS_BIT + 1){1'b1}}, chunk_index == '0 && byte_offset == '0, "grant with location")

endmodule

bind deferred_reuse_slot_allocator drsa_checker #(.CLASS_BIT(CLASS_BIT)) u_drsa_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok),
    .granted_slot(granted_slot), .chunk_grew(chunk_grew),
    .chunk_index(chunk_index), .byte_offset(byte_offset)
);
